/* design/mwm_pkg.sv */
package mwm_pkg;

   // Field widths and command limits.
   localparam int CMD_W      = 10;
   localparam int CMD_LIMIT  = 500;
   localparam int WHEELS     = 4;
   localparam int SUM_W      = 12;
   localparam int MAG_W      = 11;
   localparam int CMAX_W     = 9;
   localparam int MAG3_W     = 13;
   localparam int NUM_W      = 22;
   localparam int DUTY_W     = 11;
   localparam int DIR_W      = 2;
   localparam int DUTY_MAX   = 3 * CMD_LIMIT;
   localparam int DIV_STAGES = DUTY_W;
   localparam int FRONT_STAGES = 3;

   // Wheel order inside every per-wheel vector.
   localparam int WHEEL_FL = 0;
   localparam int WHEEL_FR = 1;
   localparam int WHEEL_RR = 2;
   localparam int WHEEL_RL = 3;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(CMD_LIMIT);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI;

   typedef enum logic [DIR_W-1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   // After the mixing stage: signed wheel sums and command magnitudes.
   typedef struct packed {
      logic [WHEELS-1:0][SUM_W-1:0] sum;
      logic [CMAX_W-1:0]            spd_mag;
      logic [CMAX_W-1:0]            trn_mag;
      logic [CMAX_W-1:0]            stf_mag;
   } mix_type;

   // After the magnitude stage: wheel magnitudes, both maxima, directions.
   typedef struct packed {
      logic [WHEELS-1:0][MAG_W-1:0] mag;
      logic [MAG_W-1:0]             wheel_max;
      logic [CMAX_W-1:0]            cmd_max;
      dir_type [WHEELS-1:0]         dir;
   } mag_type;

   // Division state carried from stage to stage.
   typedef struct packed {
      logic [WHEELS-1:0][NUM_W-1:0]  rem;
      logic [WHEELS-1:0][DUTY_W-1:0] quo;
      logic [MAG_W-1:0]              divisor;
      dir_type [WHEELS-1:0]          dir;
   } div_type;

   // Sign-extend a raw command and clamp it to the command limit.
   function automatic logic signed [SUM_W-1:0] sat_cmd(input logic [CMD_W-1:0] raw);
      logic signed [SUM_W-1:0] v;
      v = SUM_W'($signed(raw));
      if (v > SAT_HI) begin
         v = SAT_HI;
      end else if (v < SAT_LO) begin
         v = SAT_LO;
      end
      return v;
   endfunction

   // Magnitude of a wheel sum; every sum stays within three command limits.
   function automatic logic [MAG_W-1:0] abs_sum(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] n;
      n = -v;
      return v[SUM_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

endpackage

/* design/mwm_front.sv */
module mwm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [mwm_pkg::CMD_W-1:0]   speed_cmd,
   input  logic [mwm_pkg::CMD_W-1:0]   turn_cmd,
   input  logic [mwm_pkg::CMD_W-1:0]   strafe_cmd,
   output logic                        out_valid,
   input  logic                        out_ready,
   output mwm_pkg::div_type            out_data
);

   logic [mwm_pkg::FRONT_STAGES-1:0] vld_ff;
   logic [mwm_pkg::FRONT_STAGES-1:0] rdy;

   mwm_pkg::mix_type mix_ff, mix_in;
   mwm_pkg::mag_type mag_ff, mag_in;
   mwm_pkg::div_type num_ff, num_in;

   // A stage takes new data when it is empty or its successor moves on.
   assign rdy[2]    = !vld_ff[2] || out_ready;
   assign rdy[1]    = !vld_ff[1] || rdy[2];
   assign rdy[0]    = !vld_ff[0] || rdy[1];
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[2];
   assign out_data  = num_ff;

   // Stage one: saturate the commands and form the four wheel sums.
   always_comb begin
      logic signed [mwm_pkg::SUM_W-1:0] spd;
      logic signed [mwm_pkg::SUM_W-1:0] trn;
      logic signed [mwm_pkg::SUM_W-1:0] stf;
      spd = mwm_pkg::sat_cmd(speed_cmd);
      trn = mwm_pkg::sat_cmd(turn_cmd);
      stf = mwm_pkg::sat_cmd(strafe_cmd);
      mix_in.sum[mwm_pkg::WHEEL_FL] = spd + stf + trn;
      mix_in.sum[mwm_pkg::WHEEL_FR] = spd - stf - trn;
      mix_in.sum[mwm_pkg::WHEEL_RR] = spd + stf - trn;
      mix_in.sum[mwm_pkg::WHEEL_RL] = spd - stf + trn;
      mix_in.spd_mag = mwm_pkg::CMAX_W'(mwm_pkg::abs_sum(spd));
      mix_in.trn_mag = mwm_pkg::CMAX_W'(mwm_pkg::abs_sum(trn));
      mix_in.stf_mag = mwm_pkg::CMAX_W'(mwm_pkg::abs_sum(stf));
   end

   // Stage two: wheel magnitudes, directions and the two maxima.
   always_comb begin
      logic [mwm_pkg::MAG_W-1:0]  max_a;
      logic [mwm_pkg::MAG_W-1:0]  max_b;
      logic [mwm_pkg::CMAX_W-1:0] cmax;
      for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
         mag_in.mag[w] = mwm_pkg::abs_sum($signed(mix_ff.sum[w]));
         if (mix_ff.sum[w] == '0) begin
            mag_in.dir[w] = mwm_pkg::DIR_STOP;
         end else if (mix_ff.sum[w][mwm_pkg::SUM_W-1]) begin
            mag_in.dir[w] = mwm_pkg::DIR_REV;
         end else begin
            mag_in.dir[w] = mwm_pkg::DIR_FWD;
         end
      end
      max_a = (mag_in.mag[0] > mag_in.mag[1]) ? mag_in.mag[0] : mag_in.mag[1];
      max_b = (mag_in.mag[2] > mag_in.mag[3]) ? mag_in.mag[2] : mag_in.mag[3];
      mag_in.wheel_max = (max_a > max_b) ? max_a : max_b;
      cmax = (mix_ff.spd_mag > mix_ff.trn_mag) ? mix_ff.spd_mag : mix_ff.trn_mag;
      mag_in.cmd_max = (mix_ff.stf_mag > cmax) ? mix_ff.stf_mag : cmax;
   end

   // Stage three: numerators 3*|wheel|*max_command. An all-zero drive divides
   // a zero numerator by one, which gives zero duty on every wheel.
   always_comb begin
      logic [mwm_pkg::MAG3_W-1:0] mag3;
      for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
         mag3 = (mwm_pkg::MAG3_W'(mag_ff.mag[w]) << 1) + mwm_pkg::MAG3_W'(mag_ff.mag[w]);
         num_in.rem[w] = mwm_pkg::NUM_W'(mag3) * mwm_pkg::NUM_W'(mag_ff.cmd_max);
      end
      num_in.quo     = '0;
      num_in.divisor = (mag_ff.wheel_max == '0) ? mwm_pkg::MAG_W'(1) : mag_ff.wheel_max;
      num_in.dir     = mag_ff.dir;
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= in_valid;
         end
         if (rdy[1]) begin
            vld_ff[1] <= vld_ff[0];
         end
         if (rdy[2]) begin
            vld_ff[2] <= vld_ff[1];
         end
      end
   end

   // Stage data registers.
   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         mix_ff <= mix_in;
      end
      if (rdy[1] && vld_ff[0]) begin
         mag_ff <= mag_in;
      end
      if (rdy[2] && vld_ff[1]) begin
         num_ff <= num_in;
      end
   end

endmodule

/* design/mwm_divider.sv */
module mwm_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mwm_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output mwm_pkg::div_type out_data
);

   logic             vld_ff [mwm_pkg::DIV_STAGES];
   logic             rdy    [mwm_pkg::DIV_STAGES];
   mwm_pkg::div_type div_ff [mwm_pkg::DIV_STAGES];

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[mwm_pkg::DIV_STAGES-1];
   assign out_data  = div_ff[mwm_pkg::DIV_STAGES-1];

   // One restoring-division step per stage, most significant quotient bit first.
   for (genvar k = 0; k < mwm_pkg::DIV_STAGES; k++) begin : g_stage
      localparam int QBIT = mwm_pkg::DIV_STAGES - 1 - k;

      mwm_pkg::div_type         cur;
      mwm_pkg::div_type         div_in;
      logic                     cur_valid;
      logic                     next_ready;
      logic [mwm_pkg::NUM_W-1:0] shifted;

      if (k == 0) begin : g_first
         assign cur       = in_data;
         assign cur_valid = in_valid;
      end else begin : g_next
         assign cur       = div_ff[k-1];
         assign cur_valid = vld_ff[k-1];
      end

      if (k == mwm_pkg::DIV_STAGES - 1) begin : g_last
         assign next_ready = out_ready;
      end else begin : g_mid
         assign next_ready = rdy[k+1];
      end

      assign rdy[k]  = !vld_ff[k] || next_ready;
      assign shifted = mwm_pkg::NUM_W'(cur.divisor) << QBIT;

      // Subtract the shifted divisor wherever it fits and set the quotient bit.
      always_comb begin
         div_in = cur;
         for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
            if (cur.rem[w] >= shifted) begin
               div_in.rem[w]       = cur.rem[w] - shifted;
               div_in.quo[w][QBIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && cur_valid) begin
            div_ff[k] <= div_in;
         end
      end
   end

endmodule

/* design/mecanum_wheel_mixer_core.sv */
// Pipeline: 3 mixing stages, then 11 divider stages of one quotient bit each; the last
// divider stage is the result register that drives rsp_valid.
// Throughput: one request per cycle unless a held rsp_stall backs up the pipeline;
// every stage holds its own valid bit, so empty stages keep filling while a finished
// result waits on rsp_stall.
// Reset: synchronous, active high; it clears all valid bits and no result is pending.
module mecanum_wheel_mixer_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mwm_pkg::CMD_W-1:0]    req_speed_cmd,
   input  logic [mwm_pkg::CMD_W-1:0]    req_turn_cmd,
   input  logic [mwm_pkg::CMD_W-1:0]    req_strafe_cmd,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mwm_pkg::DUTY_W-1:0]   rsp_front_left_duty,
   output logic [mwm_pkg::DUTY_W-1:0]   rsp_front_right_duty,
   output logic [mwm_pkg::DUTY_W-1:0]   rsp_rear_right_duty,
   output logic [mwm_pkg::DUTY_W-1:0]   rsp_rear_left_duty,
   output logic [mwm_pkg::DIR_W-1:0]    rsp_front_left_dir,
   output logic [mwm_pkg::DIR_W-1:0]    rsp_front_right_dir,
   output logic [mwm_pkg::DIR_W-1:0]    rsp_rear_right_dir,
   output logic [mwm_pkg::DIR_W-1:0]    rsp_rear_left_dir
);

   logic             front_ready;
   logic             mid_valid;
   logic             mid_ready;
   mwm_pkg::div_type mid_data;
   mwm_pkg::div_type res_data;

   assign req_stall = !front_ready;

   // Mixing, magnitudes and numerators.
   mwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (front_ready),
      .speed_cmd  (req_speed_cmd),
      .turn_cmd   (req_turn_cmd),
      .strafe_cmd (req_strafe_cmd),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .out_data   (mid_data)
   );

   // Pipelined division; its last stage is the result register.
   mwm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (res_data)
   );

   // Result fields.
   assign rsp_front_left_duty  = res_data.quo[mwm_pkg::WHEEL_FL];
   assign rsp_front_right_duty = res_data.quo[mwm_pkg::WHEEL_FR];
   assign rsp_rear_right_duty  = res_data.quo[mwm_pkg::WHEEL_RR];
   assign rsp_rear_left_duty   = res_data.quo[mwm_pkg::WHEEL_RL];
   assign rsp_front_left_dir   = res_data.dir[mwm_pkg::WHEEL_FL];
   assign rsp_front_right_dir  = res_data.dir[mwm_pkg::WHEEL_FR];
   assign rsp_rear_right_dir   = res_data.dir[mwm_pkg::WHEEL_RR];
   assign rsp_rear_left_dir    = res_data.dir[mwm_pkg::WHEEL_RL];

endmodule

/* design/mwm_checker.sv */
module mwm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [mwm_pkg::CMD_W-1:0]    req_speed_cmd,
   input logic [mwm_pkg::CMD_W-1:0]    req_turn_cmd,
   input logic [mwm_pkg::CMD_W-1:0]    req_strafe_cmd,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [mwm_pkg::DUTY_W-1:0]   rsp_front_left_duty,
   input logic [mwm_pkg::DUTY_W-1:0]   rsp_front_right_duty,
   input logic [mwm_pkg::DUTY_W-1:0]   rsp_rear_right_duty,
   input logic [mwm_pkg::DUTY_W-1:0]   rsp_rear_left_duty,
   input logic [mwm_pkg::DIR_W-1:0]    rsp_front_left_dir,
   input logic [mwm_pkg::DIR_W-1:0]    rsp_front_right_dir,
   input logic [mwm_pkg::DIR_W-1:0]    rsp_rear_right_dir,
   input logic [mwm_pkg::DIR_W-1:0]    rsp_rear_left_dir
);

   // No result is pending right after reset.
   a_reset_clears : assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result keeps its valid and its fields.
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_front_left_duty) &&
      $stable(rsp_front_right_duty) && $stable(rsp_rear_right_duty) &&
      $stable(rsp_rear_left_duty) && $stable(rsp_front_left_dir) &&
      $stable(rsp_front_right_dir) && $stable(rsp_rear_right_dir) &&
      $stable(rsp_rear_left_dir))
      else $error("stalled result changed");

   // A wheel has zero duty exactly when its direction is stop.
   a_stop_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      ((rsp_front_left_duty == '0) == (rsp_front_left_dir == mwm_pkg::DIR_STOP)) &&
      ((rsp_front_right_duty == '0) == (rsp_front_right_dir == mwm_pkg::DIR_STOP)) &&
      ((rsp_rear_right_duty == '0) == (rsp_rear_right_dir == mwm_pkg::DIR_STOP)) &&
      ((rsp_rear_left_duty == '0) == (rsp_rear_left_dir == mwm_pkg::DIR_STOP)))
      else $error("duty and stop direction disagree");

   // Duties stay within range and direction codes are meaningful.
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      (rsp_front_left_duty <= mwm_pkg::DUTY_W'(mwm_pkg::DUTY_MAX)) &&
      (rsp_front_right_duty <= mwm_pkg::DUTY_W'(mwm_pkg::DUTY_MAX)) &&
      (rsp_rear_right_duty <= mwm_pkg::DUTY_W'(mwm_pkg::DUTY_MAX)) &&
      (rsp_rear_left_duty <= mwm_pkg::DUTY_W'(mwm_pkg::DUTY_MAX)) &&
      (rsp_front_left_dir != 2'd3) && (rsp_front_right_dir != 2'd3) &&
      (rsp_rear_right_dir != 2'd3) && (rsp_rear_left_dir != 2'd3))
      else $error("result out of range");

   // A stalled request keeps its valid and its command fields.
   a_req_holds : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_speed_cmd) &&
      $stable(req_turn_cmd) && $stable(req_strafe_cmd))
      else $error("stalled request changed");

endmodule

bind mecanum_wheel_mixer_core mwm_checker u_mwm_checker (.*);

/* sim/mecanum_wheel_mixer_core_tb.sv */
`timescale 1ns / 100ps

module mecanum_wheel_mixer_core_tb;

   localparam int RANDOM_REQUESTS = 1300;
   localparam int PHASES          = 4;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int MAX_REPORTS     = 10;
   localparam int CMD_MAX_RAW     = (1 << (mwm_pkg::CMD_W - 1)) - 1;
   localparam int CMD_MIN_RAW     = -(1 << (mwm_pkg::CMD_W - 1));

   // Pacing per random phase: sender 0 none, 1 short gaps, 2 long gaps;
   // receiver 0 never stalls, 1 light stalls, 2 heavy stalls.
   localparam int SEND_PACING [PHASES] = '{0, 1, 0, 2};
   localparam int RECV_PACING [PHASES] = '{0, 1, 2, 1};

   localparam int CMD_CORNERS [9] = '{CMD_MIN_RAW, -mwm_pkg::CMD_LIMIT - 1,
                                      -mwm_pkg::CMD_LIMIT, -1, 0, 1,
                                      mwm_pkg::CMD_LIMIT, mwm_pkg::CMD_LIMIT + 1,
                                      CMD_MAX_RAW};

   // One result: duty and direction of every wheel, in the package wheel order.
   typedef struct packed {
      logic [0:mwm_pkg::WHEELS-1][mwm_pkg::DUTY_W-1:0] duty;
      logic [0:mwm_pkg::WHEELS-1][mwm_pkg::DIR_W-1:0]  dir;
   } drive_type;

   // One directed request; the drive is given only where it is plain to see.
   typedef struct packed {
      logic [mwm_pkg::CMD_W-1:0] spd;
      logic [mwm_pkg::CMD_W-1:0] trn;
      logic [mwm_pkg::CMD_W-1:0] stf;
      logic                      has_want;
      drive_type                 want;
   } drive_case_type;

   localparam logic [0:mwm_pkg::WHEELS-1][mwm_pkg::DUTY_W-1:0] DUTY_FULL =
      {mwm_pkg::WHEELS{mwm_pkg::DUTY_W'(mwm_pkg::DUTY_MAX)}};
   localparam logic [0:mwm_pkg::WHEELS-1][mwm_pkg::DUTY_W-1:0] DUTY_NONE = '0;
   localparam logic [0:mwm_pkg::WHEELS-1][mwm_pkg::DIR_W-1:0]  ALL_FWD   =
      {mwm_pkg::DIR_FWD, mwm_pkg::DIR_FWD, mwm_pkg::DIR_FWD, mwm_pkg::DIR_FWD};
   localparam logic [0:mwm_pkg::WHEELS-1][mwm_pkg::DIR_W-1:0]  ALL_REV   =
      {mwm_pkg::DIR_REV, mwm_pkg::DIR_REV, mwm_pkg::DIR_REV, mwm_pkg::DIR_REV};
   localparam logic [0:mwm_pkg::WHEELS-1][mwm_pkg::DIR_W-1:0]  ALL_STOP  =
      {mwm_pkg::DIR_STOP, mwm_pkg::DIR_STOP, mwm_pkg::DIR_STOP, mwm_pkg::DIR_STOP};
   localparam drive_type NO_WANT = '0;

   localparam int DIRECTED_ROWS = 20;
   localparam drive_case_type DRIVE_CASES [DIRECTED_ROWS] = '{
      '{10'sd0, 10'sd0, 10'sd0, 1'b1, '{DUTY_NONE, ALL_STOP}},
      '{10'sd500, 10'sd0, 10'sd0, 1'b1, '{DUTY_FULL, ALL_FWD}},
      '{-10'sd500, 10'sd0, 10'sd0, 1'b1, '{DUTY_FULL, ALL_REV}},
      '{10'h1FF, 10'sd0, 10'sd0, 1'b1, '{DUTY_FULL, ALL_FWD}},
      '{10'h200, 10'sd0, 10'sd0, 1'b1, '{DUTY_FULL, ALL_REV}},
      '{10'sd0, 10'sd500, 10'sd0, 1'b1,
        '{DUTY_FULL, {mwm_pkg::DIR_FWD, mwm_pkg::DIR_REV, mwm_pkg::DIR_REV,
                      mwm_pkg::DIR_FWD}}},
      '{10'sd0, 10'sd0, 10'sd500, 1'b1,
        '{DUTY_FULL, {mwm_pkg::DIR_FWD, mwm_pkg::DIR_REV, mwm_pkg::DIR_FWD,
                      mwm_pkg::DIR_REV}}},
      '{10'sd0, -10'sd501, 10'sd0, 1'b1,
        '{DUTY_FULL, {mwm_pkg::DIR_REV, mwm_pkg::DIR_FWD, mwm_pkg::DIR_FWD,
                      mwm_pkg::DIR_REV}}},
      '{10'sd500, 10'sd500, 10'sd500, 1'b1,
        '{{11'd1500, 11'd500, 11'd500, 11'd500},
          {mwm_pkg::DIR_FWD, mwm_pkg::DIR_REV, mwm_pkg::DIR_FWD, mwm_pkg::DIR_FWD}}},
      '{10'sd500, 10'sd500, 10'sd0, 1'b1,
        '{{11'd1500, 11'd0, 11'd0, 11'd1500},
          {mwm_pkg::DIR_FWD, mwm_pkg::DIR_STOP, mwm_pkg::DIR_STOP, mwm_pkg::DIR_FWD}}},
      '{10'sd1, 10'sd0, 10'sd0, 1'b1, '{{mwm_pkg::WHEELS{11'd3}}, ALL_FWD}},
      '{10'sd1, -10'sd1, 10'sd0, 1'b1,
        '{{11'd0, 11'd3, 11'd3, 11'd0},
          {mwm_pkg::DIR_STOP, mwm_pkg::DIR_FWD, mwm_pkg::DIR_FWD, mwm_pkg::DIR_STOP}}},
      '{-10'sd1, -10'sd1, -10'sd1, 1'b0, NO_WANT},
      '{10'sd300, -10'sd200, 10'sd100, 1'b0, NO_WANT},
      '{10'h1FF, 10'h200, 10'h1FF, 1'b0, NO_WANT},
      '{-10'sd501, 10'sd501, -10'sd501, 1'b0, NO_WANT},
      '{10'sd7, 10'sd13, -10'sd2, 1'b0, NO_WANT},
      '{10'h155, 10'h2AA, 10'h0F0, 1'b0, NO_WANT},
      '{-10'sd500, -10'sd500, -10'sd500, 1'b0, NO_WANT},
      '{10'sd250, 10'sd0, -10'sd250, 1'b0, NO_WANT}
   };

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [mwm_pkg::CMD_W-1:0]    req_speed_cmd;
   logic [mwm_pkg::CMD_W-1:0]    req_turn_cmd;
   logic [mwm_pkg::CMD_W-1:0]    req_strafe_cmd;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [mwm_pkg::DUTY_W-1:0]   rsp_front_left_duty;
   logic [mwm_pkg::DUTY_W-1:0]   rsp_front_right_duty;
   logic [mwm_pkg::DUTY_W-1:0]   rsp_rear_right_duty;
   logic [mwm_pkg::DUTY_W-1:0]   rsp_rear_left_duty;
   logic [mwm_pkg::DIR_W-1:0]    rsp_front_left_dir;
   logic [mwm_pkg::DIR_W-1:0]    rsp_front_right_dir;
   logic [mwm_pkg::DIR_W-1:0]    rsp_rear_right_dir;
   logic [mwm_pkg::DIR_W-1:0]    rsp_rear_left_dir;

   // Typed drive of the request on the bus, moved together with its payload.
   logic                         cmd_has_want;
   drive_type                    cmd_want;

   drive_type           queued_drives [$];
   string               wheel_names [mwm_pkg::WHEELS] = '{"front left", "front right",
                                                          "rear right", "rear left"};
   int                  send_pacing;
   int                  recv_pacing;
   int                  burst_left;
   int                  stall_run;
   int                  quiet_cycles;
   int                  error_count;
   int                  accepted_count;
   int                  checked_count;
   int                  clamped_count;
   int                  stopped_count;

   mecanum_wheel_mixer_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_speed_cmd        (req_speed_cmd),
      .req_turn_cmd         (req_turn_cmd),
      .req_strafe_cmd       (req_strafe_cmd),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_front_left_duty  (rsp_front_left_duty),
      .rsp_front_right_duty (rsp_front_right_duty),
      .rsp_rear_right_duty  (rsp_rear_right_duty),
      .rsp_rear_left_duty   (rsp_rear_left_duty),
      .rsp_front_left_dir   (rsp_front_left_dir),
      .rsp_front_right_dir  (rsp_front_right_dir),
      .rsp_rear_right_dir   (rsp_rear_right_dir),
      .rsp_rear_left_dir    (rsp_rear_left_dir)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Sign-extend a raw command and clamp it to the command limit.
   function automatic int clamp_cmd(input logic [mwm_pkg::CMD_W-1:0] raw);
      int v;
      v = $signed(raw);
      if (v > mwm_pkg::CMD_LIMIT) begin
         v = mwm_pkg::CMD_LIMIT;
      end else if (v < -mwm_pkg::CMD_LIMIT) begin
         v = -mwm_pkg::CMD_LIMIT;
      end
      return v;
   endfunction

   function automatic int abs_int(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // Mix one command into four wheel sums and scale them to PWM duty.
   function automatic drive_type mix_wheels(input logic [mwm_pkg::CMD_W-1:0] spd_raw,
                                            input logic [mwm_pkg::CMD_W-1:0] trn_raw,
                                            input logic [mwm_pkg::CMD_W-1:0] stf_raw);
      int        spd, trn, stf, cmd_max, wheel_max;
      int        wheel_sum [mwm_pkg::WHEELS];
      drive_type d;
      spd = clamp_cmd(spd_raw);
      trn = clamp_cmd(trn_raw);
      stf = clamp_cmd(stf_raw);
      wheel_sum[mwm_pkg::WHEEL_FL] = spd + stf + trn;
      wheel_sum[mwm_pkg::WHEEL_FR] = spd - stf - trn;
      wheel_sum[mwm_pkg::WHEEL_RR] = spd + stf - trn;
      wheel_sum[mwm_pkg::WHEEL_RL] = spd - stf + trn;
      cmd_max = abs_int(spd);
      if (abs_int(trn) > cmd_max) begin
         cmd_max = abs_int(trn);
      end
      if (abs_int(stf) > cmd_max) begin
         cmd_max = abs_int(stf);
      end
      wheel_max = 0;
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         if (abs_int(wheel_sum[i]) > wheel_max) begin
            wheel_max = abs_int(wheel_sum[i]);
         end
      end
      // With every sum at zero the division is skipped and all wheels stop.
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         d.duty[i] = (wheel_max == 0) ? '0 :
                     mwm_pkg::DUTY_W'((3 * abs_int(wheel_sum[i]) * cmd_max) / wheel_max);
         if (wheel_sum[i] > 0) begin
            d.dir[i] = mwm_pkg::DIR_FWD;
         end else if (wheel_sum[i] < 0) begin
            d.dir[i] = mwm_pkg::DIR_REV;
         end else begin
            d.dir[i] = mwm_pkg::DIR_STOP;
         end
      end
      return d;
   endfunction

   function automatic bit is_clamped(input logic [mwm_pkg::CMD_W-1:0] raw);
      return clamp_cmd(raw) != int'($signed(raw));
   endfunction

   // Random command: full raw range, legal range, corners, zero, small, saturating.
   function automatic logic [mwm_pkg::CMD_W-1:0] pick_cmd();
      case ($urandom_range(0, 9))
         0, 1, 2: return mwm_pkg::CMD_W'($urandom_range(0, (1 << mwm_pkg::CMD_W) - 1));
         3, 4, 5: return mwm_pkg::CMD_W'(int'($urandom_range(0, 2 * mwm_pkg::CMD_LIMIT)) -
                                         mwm_pkg::CMD_LIMIT);
         6:       return mwm_pkg::CMD_W'(CMD_CORNERS[$urandom_range(0, 8)]);
         7:       return '0;
         8:       return mwm_pkg::CMD_W'(int'($urandom_range(0, 16)) - 8);
         default: begin
            if ($urandom_range(0, 1) == 1) begin
               return mwm_pkg::CMD_W'(int'($urandom_range(mwm_pkg::CMD_LIMIT + 1,
                                                          CMD_MAX_RAW)));
            end
            return mwm_pkg::CMD_W'(-int'($urandom_range(mwm_pkg::CMD_LIMIT + 1,
                                                        -CMD_MIN_RAW)));
         end
      endcase
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   // Present one request and hold it until it is taken; bursts are split by gaps.
   task automatic send_cmd(input logic [mwm_pkg::CMD_W-1:0] spd,
                           input logic [mwm_pkg::CMD_W-1:0] trn,
                           input logic [mwm_pkg::CMD_W-1:0] stf, input logic has_want,
                           input drive_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case (send_pacing)
            0:       gap = 0;
            1:       gap = $urandom_range(0, 3);
            default: gap = $urandom_range(1, 20);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_speed_cmd  <= spd;
      req_turn_cmd   <= trn;
      req_strafe_cmd <= stf;
      cmd_has_want   <= has_want;
      cmd_want       <= want;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // Stop sending and wait until every queued drive has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (queued_drives.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Receiver stall pattern: runs of stall or flow, shaped by the pacing.
   always @(posedge clock) begin
      if (reset) begin
         stall_run = 0;
         rsp_stall <= 1'b0;
      end else if (stall_run == 0) begin
         case (recv_pacing)
            0: begin
               stall_run = $urandom_range(1, 8);
               rsp_stall <= 1'b0;
            end
            1: begin
               stall_run = $urandom_range(1, 3);
               rsp_stall <= ($urandom_range(0, 99) < 30);
            end
            default: begin
               stall_run = $urandom_range(1, 30);
               rsp_stall <= ($urandom_range(0, 99) < 60);
            end
         endcase
      end else begin
         stall_run--;
      end
   end

   // Record each accepted request and check each accepted result.
   always @(posedge clock) begin
      drive_type want;
      drive_type seen;
      bit        any_stop;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            queued_drives.push_back(cmd_has_want ? cmd_want :
                                    mix_wheels(req_speed_cmd, req_turn_cmd,
                                               req_strafe_cmd));
            accepted_count++;
            if (is_clamped(req_speed_cmd) || is_clamped(req_turn_cmd) ||
                is_clamped(req_strafe_cmd)) begin
               clamped_count++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            seen.duty = {rsp_front_left_duty, rsp_front_right_duty,
                         rsp_rear_right_duty, rsp_rear_left_duty};
            seen.dir  = {rsp_front_left_dir, rsp_front_right_dir,
                         rsp_rear_right_dir, rsp_rear_left_dir};
            if (queued_drives.size() == 0) begin
               report_error("result arrived with no request pending");
            end else begin
               want = queued_drives.pop_front();
               any_stop = 1'b0;
               for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
                  if (seen.duty[i] !== want.duty[i]) begin
                     report_error($sformatf("result %0d %s duty: expected %0d, got %0d",
                                            checked_count, wheel_names[i],
                                            want.duty[i], seen.duty[i]));
                  end
                  if (seen.dir[i] !== want.dir[i]) begin
                     report_error($sformatf("result %0d %s dir: expected %0d, got %0d",
                                            checked_count, wheel_names[i],
                                            want.dir[i], seen.dir[i]));
                  end
                  if (want.dir[i] == mwm_pkg::DIR_STOP) begin
                     any_stop = 1'b1;
                  end
               end
               if (any_stop) begin
                  stopped_count++;
               end
            end
            checked_count++;
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: nothing moved for %0d cycles, %0d results outstanding",
                  quiet_cycles, queued_drives.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stimulus: reset, directed table, then random phases with varied pacing.
   initial begin
      logic [mwm_pkg::CMD_W-1:0] spd, trn, stf;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_speed_cmd  <= '0;
      req_turn_cmd   <= '0;
      req_strafe_cmd <= '0;
      cmd_has_want   <= 1'b0;
      cmd_want       <= NO_WANT;
      send_pacing = 1;
      recv_pacing = 1;
      burst_left  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         send_cmd(DRIVE_CASES[n].spd, DRIVE_CASES[n].trn, DRIVE_CASES[n].stf,
                  DRIVE_CASES[n].has_want, DRIVE_CASES[n].want);
      end
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         send_pacing = SEND_PACING[p];
         recv_pacing = RECV_PACING[p];
         for (int n = 0; n < RANDOM_REQUESTS / PHASES; n++) begin
            spd = pick_cmd();
            trn = pick_cmd();
            stf = pick_cmd();
            // Some commands are shaped so that wheel sums cancel.
            case ($urandom_range(0, 11))
               0: trn = -spd;
               1: begin
                  stf = -spd;
                  trn = '0;
               end
               2: begin
                  trn = spd;
                  stf = spd;
               end
               3: begin
                  trn = '0;
                  stf = '0;
               end
               default: ;
            endcase
            send_cmd(spd, trn, stf, 1'b0, NO_WANT);
         end
         wait_drained();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (queued_drives.size() != 0) begin
         report_error($sformatf("%0d results never arrived", queued_drives.size()));
      end
      $display("Summary: %0d requests (%0d directed), %0d with a saturated command field.",
               accepted_count, DIRECTED_ROWS, clamped_count);
      $display("Summary: %0d results checked, %0d with a stopped wheel, %0d errors.",
               checked_count, stopped_count, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
